// ----- sv/lse_pkg.sv -----
// Package for the LSB stego extraction unit.
// Holds the item types, the push bundle between core and queue, and constants.
// No dependencies.
package lse_pkg;

  // Depth of the result queue, at least two.
  localparam int unsigned LseFifoDepth = 4;

  // Header length in components and the bit count that a zero header stands for.
  localparam logic [1:0] HeaderLen    = 2'd3;
  localparam logic [3:0] FullByteBits = 4'd8;
  localparam logic [2:0] TopBitPos    = 3'd7;
  localparam logic [7:0] TermByte     = 8'h00;

  typedef struct packed {
    logic [7:0] component;
    logic       image_start;
    logic       image_end;
  } lse_in_t;

  typedef struct packed {
    logic [7:0] message_byte;
    logic       last;
    logic       ran_out;
  } lse_out_t;

  // Results produced by one accepted item, in order.
  typedef struct packed {
    logic [1:0] count;
    lse_out_t   res0;
    lse_out_t   res1;
  } lse_push_t;

endpackage

// ----- sv/lse_core.sv -----
// Extraction core: header decode, bit merge into the partial byte, terminator logic.
// Depends on lse_pkg.
module lse_core (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  lse_pkg::lse_in_t in_data_i,
  output lse_pkg::lse_push_t push_o
);
  import lse_pkg::*;

  logic [1:0] hc_q, hc_d;
  logic [3:0] bpc_q, bpc_d;
  logic [2:0] pos_q, pos_d;
  logic [7:0] pb_q, pb_d;
  logic       fin_q, fin_d;

  // Compute next state and the results of the accepted item
  always_comb begin
    logic [1:0]  hc;
    logic [3:0]  bpc;
    logic [2:0]  pos;
    logic [7:0]  pb;
    logic        fin;
    logic [3:0]  k;
    logic [3:0]  filled;
    logic [3:0]  total;
    logic [7:0]  masked;
    logic [15:0] win;
    logic [7:0]  byte_v;
    logic        term;
    lse_push_t   push;

    hc   = hc_q;
    bpc  = bpc_q;
    pos  = pos_q;
    pb   = pb_q;
    fin  = fin_q;
    k      = '0;
    filled = '0;
    total  = '0;
    masked = '0;
    win    = '0;
    byte_v = '0;
    term   = 1'b0;
    push   = '0;

    if (accept_i) begin
      // restart on a new image
      if (in_data_i.image_start) begin
        hc  = '0;
        bpc = '0;
        pos = TopBitPos;
        pb  = '0;
        fin = 1'b0;
      end
      if (!fin) begin
        if (hc < HeaderLen) begin
          // gather one header bit
          bpc = bpc | ({3'b000, in_data_i.component[0]} << hc);
          hc  = hc + 2'd1;
          if (hc == HeaderLen && bpc == 4'd0) begin
            bpc = FullByteBits;
          end
        end else begin
          // merge k low bits below the bits already filled
          k      = (bpc > FullByteBits) ? FullByteBits : bpc;
          filled = 4'(TopBitPos - pos);
          total  = filled + k;
          masked = in_data_i.component & ~(8'hff << k);
          win    = {pb, 8'h00} | ({8'h00, masked} << (5'd16 - {1'b0, total}));
          if (total >= FullByteBits) begin
            byte_v = win[15:8];
            pb     = win[7:0];
            pos    = 3'(4'd15 - total);
            if (byte_v == TermByte) begin
              push.res0  = '{message_byte: TermByte, last: 1'b1, ran_out: 1'b0};
              push.count = 2'd1;
              fin        = 1'b1;
              term       = 1'b1;
            end else begin
              push.res0  = '{message_byte: byte_v, last: 1'b0, ran_out: 1'b0};
              push.count = 2'd1;
            end
          end else begin
            pb  = win[15:8];
            pos = 3'(4'd7 - total);
          end
        end
        // end of image closes the message
        if (in_data_i.image_end && !term) begin
          if (push.count == 2'd0) begin
            push.res0 = '{message_byte: TermByte, last: 1'b1, ran_out: 1'b1};
          end else begin
            push.res1 = '{message_byte: TermByte, last: 1'b1, ran_out: 1'b1};
          end
          push.count = push.count + 2'd1;
          fin        = 1'b1;
        end
      end
    end

    hc_d   = hc;
    bpc_d  = bpc;
    pos_d  = pos;
    pb_d   = pb;
    fin_d  = fin;
    push_o = push;
  end

  // Hold extraction state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hc_q  <= '0;
      bpc_q <= '0;
      pos_q <= TopBitPos;
      pb_q  <= '0;
      fin_q <= 1'b0;
    end else begin
      hc_q  <= hc_d;
      bpc_q <= bpc_d;
      pos_q <= pos_d;
      pb_q  <= pb_d;
      fin_q <= fin_d;
    end
  end

endmodule

// ----- sv/lse_out_fifo.sv -----
// Result queue: takes up to two results per cycle, delivers one per cycle while out_stall_i is low.
// Depends on lse_pkg.
module lse_out_fifo #(
  parameter int unsigned FifoDepth = lse_pkg::LseFifoDepth
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lse_pkg::lse_push_t push_i,
  output logic               full_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lse_pkg::lse_out_t  out_data_o
);
  import lse_pkg::*;

  localparam int unsigned PtrW = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned CntW = $clog2(FifoDepth + 1);

  lse_out_t            mem_q [FifoDepth];
  logic [PtrW-1:0]     head_q, head_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [PtrW-1:0]     wr0, wr1;
  logic                pop;

  // Wrap an index sum into the queue depth
  function automatic logic [PtrW-1:0] wrap_idx(input logic [CntW:0] sum);
    logic [CntW:0] s;
    s = sum;
    if (s >= (CntW+1)'(FifoDepth)) begin
      s = s - (CntW+1)'(FifoDepth);
    end
    return s[PtrW-1:0];
  endfunction

  assign pop         = (cnt_q != '0) && !out_stall_i;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[head_q];
  // Leave room for two results before taking another item
  assign full_o      = (cnt_q > CntW'(FifoDepth - 2));

  assign wr0 = wrap_idx({1'b0, CntW'(head_q)} + {1'b0, cnt_q});
  assign wr1 = wrap_idx({1'b0, CntW'(wr0)} + (CntW+1)'(1));

  // Advance head and count
  always_comb begin
    head_d = head_q;
    if (pop) begin
      head_d = wrap_idx({1'b0, CntW'(head_q)} + (CntW+1)'(1));
    end
    cnt_d = cnt_q + CntW'(push_i.count) - CntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
    end
  end

  // Store pushed results
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr0] <= push_i.res0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr1] <= push_i.res1;
    end
  end

endmodule

// ----- sv/lsb_stego_extract_unit.sv -----
// LSB stego extraction unit: top level joining the core and the result queue.
// Depends on lse_pkg, lse_core and lse_out_fifo.
//
// Input channel carries one color component per item with image_start and
// image_end flags. The first three components of an image give the bits per
// component in their low bits; later components give hidden bits that are
// packed MSB first into bytes. Each result on the output channel is
// a nonzero message byte, or the zero terminator with last set (ran_out set
// when the image ended before a zero byte).
// Throughput: one component per cycle while in_stall_o is low. A component
// that yields two results (a byte and an end-of-image terminator) puts both
// into the result queue in that cycle; the queue drains one per cycle while
// out_stall_i is low, and results leave it in order behind earlier ones.
// in_stall_o rises when the result queue has no room for two more results,
// so a stalled receiver backs up into the input after FifoDepth-1 results.
// Reset clears the extraction state as if a new image had started and
// empties the queue.
module lsb_stego_extract_unit #(
  parameter int unsigned FifoDepth = lse_pkg::LseFifoDepth
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  lse_pkg::lse_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output lse_pkg::lse_out_t out_data_o
);
  import lse_pkg::*;

  lse_push_t push;
  logic      full;
  logic      accept;

  // Accept an item when the queue has room
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  lse_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .push_o    (push)
  );

  lse_out_fifo #(
    .FifoDepth (FifoDepth)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
